// File: hdl/encoder_speed_window_stats_top_assert.svh
// assertion macros shared by the checker of the encoder speed window block
`ifndef ENCODER_SPEED_WINDOW_STATS_TOP_ASSERT_SVH
`define ENCODER_SPEED_WINDOW_STATS_TOP_ASSERT_SVH

// property holds in the same cycle as its trigger
`define ESWS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("esws check failed");

// property holds in the cycle after its trigger
`define ESWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("esws check failed");

`endif

// File: hdl/esws_pkg.sv
// types and constants of the encoder speed window statistics block
package esws_pkg;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_SERVICE = 1'b1;

  localparam logic [15:0] PERIOD_RESET = 16'd10;

  // first member lands in the highest bits
  typedef struct packed {
    logic [31:0] invalid_total;
    logic [15:0] right_count;
    logic [31:0] left_count;
    logic [31:0] now_ms;
  } in_data_t;

  typedef struct packed {
    logic     op;
    in_data_t data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] invalid_in_motion;
    logic [15:0] right_abs_peak;
    logic [31:0] left_abs_peak;
    logic [31:0] right_both_abs_sum;
    logic [31:0] left_both_abs_sum;
    logic [31:0] right_abs_sum;
    logic [31:0] left_abs_sum;
    logic [31:0] both_motion_samples;
    logic [31:0] motion_samples;
    logic [15:0] right_delta;
    logic [31:0] left_delta;
    logic [31:0] window_ms;
  } result_t;

  localparam int IN_DATA_BITS  = $bits(in_data_t);
  localparam int RESULT_BITS   = $bits(result_t);

endpackage

// File: hdl/esws_in_stage.sv
// input register stage holding one accepted item
module esws_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  esws_pkg::in_item_t s_item,
  input  logic              advance,
  output logic              item_valid,
  output esws_pkg::in_item_t item
);
  import esws_pkg::*;

  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

endmodule

// File: hdl/esws_core.sv
// sample state, statistics and the per-item datapath
module esws_core #(
  parameter int RIGHT_COUNTER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [15:0]        cfg_data,
  input  logic               proc,
  input  esws_pkg::in_item_t item,
  output logic               has_result,
  output esws_pkg::result_t  result
);
  import esws_pkg::*;

  localparam int RB = RIGHT_COUNTER_BITS;

  logic [15:0]   sample_period;
  logic [31:0]   prev_left;
  logic [RB-1:0] prev_right;
  logic [31:0]   prev_invalid;
  logic [31:0]   last_sample_time;
  logic [31:0]   next_due_time;
  logic [31:0]   motion_count;
  logic [31:0]   both_count;
  logic [31:0]   sum_left;
  logic [31:0]   sum_right;
  logic [31:0]   sum_left_both;
  logic [31:0]   sum_right_both;
  logic [31:0]   peak_left;
  logic [15:0]   peak_right;
  logic [31:0]   invalid_accum;

  logic [31:0]   motion_count_next;
  logic [31:0]   both_count_next;
  logic [31:0]   sum_left_next;
  logic [31:0]   sum_right_next;
  logic [31:0]   sum_left_both_next;
  logic [31:0]   sum_right_both_next;
  logic [31:0]   peak_left_next;
  logic [15:0]   peak_right_next;
  logic [31:0]   invalid_accum_next;
  logic [31:0]   next_due_time_next;

  logic [31:0]   period32;
  logic [31:0]   due_diff;
  logic          due;
  logic [31:0]   ldelta;
  logic [31:0]   lmag;
  logic [31:0]   right_ext;
  logic [RB-1:0] right_in;
  logic [RB-1:0] rdelta;
  logic [RB-1:0] rmag;
  logic [31:0]   rmag32;
  logic [31:0]   rdelta_sx;
  logic [31:0]   invd;
  logic [31:0]   window;
  logic          left_moved;
  logic          right_moved;
  logic [31:0]   due_adv;
  logic [31:0]   behind_diff;

  assign period32  = {16'd0, sample_period};
  assign due_diff  = item.data.now_ms - next_due_time;
  assign due       = (item.op == OP_SERVICE) && !due_diff[31];

  assign ldelta    = item.data.left_count - prev_left;
  assign lmag      = ldelta[31] ? (32'd0 - ldelta) : ldelta;

  // right counter wraps at its own width
  assign right_ext = {16'd0, item.data.right_count};
  assign right_in  = right_ext[RB-1:0];
  assign rdelta    = right_in - prev_right;
  assign rmag      = rdelta[RB-1] ? (RB'(0) - rdelta) : rdelta;
  assign rmag32    = 32'(rmag);
  assign rdelta_sx = 32'(signed'(rdelta));

  assign invd      = item.data.invalid_total - prev_invalid;
  assign window    = item.data.now_ms - last_sample_time;

  assign left_moved  = (lmag != 32'd0);
  assign right_moved = (rmag != '0);

  always_comb begin
    motion_count_next   = motion_count;
    both_count_next     = both_count;
    sum_left_next       = sum_left;
    sum_right_next      = sum_right;
    sum_left_both_next  = sum_left_both;
    sum_right_both_next = sum_right_both;
    peak_left_next      = peak_left;
    peak_right_next     = peak_right;
    invalid_accum_next  = invalid_accum;
    if (left_moved || right_moved) begin
      motion_count_next  = motion_count + 32'd1;
      sum_left_next      = sum_left + lmag;
      sum_right_next     = sum_right + rmag32;
      invalid_accum_next = invalid_accum + invd;
      if (lmag > peak_left) begin
        peak_left_next = lmag;
      end
      if (rmag32 > {16'd0, peak_right}) begin
        peak_right_next = rmag32[15:0];
      end
    end
    if (left_moved && right_moved) begin
      both_count_next     = both_count + 32'd1;
      sum_left_both_next  = sum_left_both + lmag;
      sum_right_both_next = sum_right_both + rmag32;
    end
  end

  // advance by one period, resync to now plus period when behind
  assign due_adv     = next_due_time + period32;
  assign behind_diff = item.data.now_ms - due_adv;
  assign next_due_time_next = behind_diff[31] ? due_adv : (item.data.now_ms + period32);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= PERIOD_RESET;
    end else if (cfg_valid) begin
      sample_period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left        <= '0;
      prev_right       <= '0;
      prev_invalid     <= '0;
      last_sample_time <= '0;
      next_due_time    <= '0;
      motion_count     <= '0;
      both_count       <= '0;
      sum_left         <= '0;
      sum_right        <= '0;
      sum_left_both    <= '0;
      sum_right_both   <= '0;
      peak_left        <= '0;
      peak_right       <= '0;
      invalid_accum    <= '0;
    end else if (proc && item.op == OP_START) begin
      prev_left        <= item.data.left_count;
      prev_right       <= right_in;
      prev_invalid     <= item.data.invalid_total;
      last_sample_time <= item.data.now_ms;
      next_due_time    <= item.data.now_ms + period32;
      motion_count     <= '0;
      both_count       <= '0;
      sum_left         <= '0;
      sum_right        <= '0;
      sum_left_both    <= '0;
      sum_right_both   <= '0;
      peak_left        <= '0;
      peak_right       <= '0;
      invalid_accum    <= '0;
    end else if (proc && due) begin
      prev_left        <= item.data.left_count;
      prev_right       <= right_in;
      prev_invalid     <= item.data.invalid_total;
      last_sample_time <= item.data.now_ms;
      next_due_time    <= next_due_time_next;
      motion_count     <= motion_count_next;
      both_count       <= both_count_next;
      sum_left         <= sum_left_next;
      sum_right        <= sum_right_next;
      sum_left_both    <= sum_left_both_next;
      sum_right_both   <= sum_right_both_next;
      peak_left        <= peak_left_next;
      peak_right       <= peak_right_next;
      invalid_accum    <= invalid_accum_next;
    end
  end

  assign has_result = due;

  always_comb begin
    result.window_ms           = window;
    result.left_delta          = ldelta;
    result.right_delta         = rdelta_sx[15:0];
    result.motion_samples      = motion_count_next;
    result.both_motion_samples = both_count_next;
    result.left_abs_sum        = sum_left_next;
    result.right_abs_sum       = sum_right_next;
    result.left_both_abs_sum   = sum_left_both_next;
    result.right_both_abs_sum  = sum_right_both_next;
    result.left_abs_peak       = peak_left_next;
    result.right_abs_peak      = peak_right_next;
    result.invalid_in_motion   = invalid_accum_next;
  end

endmodule

// File: hdl/esws_out_stage.sv
// result register facing the output stream
module esws_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  esws_pkg::result_t result,
  output logic              m_tvalid,
  input  logic              m_tready,
  output esws_pkg::result_t m_result
);
  import esws_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_result <= result;
    end
  end

endmodule

// File: hdl/encoder_speed_window_stats_top.sv
// encoder speed window statistics: top level
//
// input stream s_*: one item per transaction, s_tuser is the operation
// (start or service tick), s_tdata carries time, counts and invalid total.
// a start item loads baselines, clears the statistics and schedules the
// first sample one period ahead; it gives no result. a service item gives
// one result on m_* once the wrap-safe due time is reached, else nothing.
// cfg_*: writes sample_period_ms; cfg_ready is always high, so write it
// only while no item is in flight.
// an accepted item is held in the input register; when it advances it is
// processed into the result register, and m_tvalid rises as that register
// is loaded.
// throughput: one item per cycle unless a result waits on m_tready; the
// statistics update is a single pass of adders and compares between the
// input register and the state. a stalled receiver holds the result register;
// one more item is taken into the input register, then s_tready drops until
// m_tready returns. reset clears the statistics, baselines and due time to
// zero and sets the period to 10 ms.
module encoder_speed_window_stats_top #(
  parameter int RIGHT_COUNTER_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // now_ms[31:0], left_count[63:32], right_count[79:64], invalid_total[111:80]
  input  logic [111:0] s_tdata,
  // operation[0]
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // window_ms, left_delta, right_delta, motion_samples, both_motion_samples,
  // left_abs_sum, right_abs_sum, left_both_abs_sum, right_both_abs_sum,
  // left_abs_peak, right_abs_peak, invalid_in_motion (lowest first)
  output logic [351:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);
  import esws_pkg::*;

  in_item_t s_item;
  in_item_t item;
  logic     item_valid;
  logic     advance;
  logic     has_result;
  result_t  result;
  result_t  m_result;

  assign s_item.op   = s_tuser[0];
  assign s_item.data = in_data_t'(s_tdata);
  assign cfg_ready   = 1'b1;
  assign advance     = item_valid && (!m_tvalid || m_tready);
  assign m_tdata     = m_result;

  esws_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_item     (s_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  esws_core #(
    .RIGHT_COUNTER_BITS (RIGHT_COUNTER_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .proc       (advance),
    .item       (item),
    .has_result (has_result),
    .result     (result)
  );

  esws_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && has_result),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_result (m_result)
  );

endmodule

// File: hdl/esws_checker.sv
// port-level checks for the encoder speed window block, bound to the top
`include "encoder_speed_window_stats_top_assert.svh"

module esws_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [0:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [351:0] m_tdata
);
  import esws_pkg::*;

  // a stalled result keeps its data
  `ESWS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // checks that every new result comes from a service item accepted at the input
  `ESWS_ASSERT_SAME(a_rose_from_service, $rose(m_tvalid), $past(s_tvalid && s_tready, 2) && $past(s_tuser[0] == OP_SERVICE, 2))

  // a moving left side always leaves a nonzero left peak
  `ESWS_ASSERT_SAME(a_left_peak, m_tvalid && m_tdata[63:32] != 32'd0, m_tdata[303:272] != 32'd0)

endmodule

bind encoder_speed_window_stats_top esws_checker u_esws_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
